// File: sv/psc_pkg.sv
// ----------------------------------------------------------------------------
// Packet scramble codec package
// Word types, operation and status codes, and the framing marker tables.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;
    localparam logic [1:0] OP_DECODE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam int FRAME_EXTRA = 24;
    localparam int HEAD_BYTES  = 12;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  byte_index;
        logic [7:0]  data_byte;
        logic [8:0]  packet_length;
        logic [31:0] salt_front;
        logic [31:0] salt_back;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [8:0] result_length;
        logic [1:0] status;
    } t_out_word;

    typedef logic [7:0] t_mark [8];

    localparam t_mark FRONT_MARK = '{8'd23, 8'd34, 8'd232, 8'd45, 8'd34, 8'd53, 8'd28, 8'd214};
    localparam t_mark BACK_MARK  = '{8'd40, 8'd92, 8'd34, 8'd234, 8'd4, 8'd82, 8'd8, 8'd42};

    // Byte k of the 24 framing bytes: front salt, front marker, back marker, back salt.
    function automatic logic [7:0] frame_byte(input logic [4:0] k, input logic [31:0] sf,
                                              input logic [31:0] sb);
        logic [7:0] b;
        if (k < 5'd4) begin
            b = sf[8*k[1:0] +: 8];
        end else if (k < 5'd12) begin
            b = FRONT_MARK[3'(k - 5'd4)];
        end else if (k < 5'd20) begin
            b = BACK_MARK[3'(k - 5'd12)];
        end else begin
            b = sb[8*k[1:0] +: 8];
        end
        return b;
    endfunction

    // Expected byte for check step k: front marker first, then back marker.
    function automatic logic [7:0] check_byte(input logic [3:0] k);
        logic [7:0] b;
        if (k[3]) begin
            b = BACK_MARK[k[2:0]];
        end else begin
            b = FRONT_MARK[k[2:0]];
        end
        return b;
    endfunction

endpackage

// File: sv/packet_scramble_codec.sv
// ----------------------------------------------------------------------------
// Packet scramble codec
// Byte buffer with framed encode and checked decode through XOR diffusion.
// ----------------------------------------------------------------------------
// A write or a read holds the input off until its result is taken into the output register.
// Reset is synchronous and clears the sequencer, the output valid and the session key.
// The buffer contents are not cleared by reset.
module packet_scramble_codec #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  psc_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output psc_pkg::t_out_word  o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [63:0]         i_cfg_data
);
    import psc_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int NW = AW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_FIN    = 4'd2;
    localparam logic [3:0] S_EMOVE  = 4'd3;
    localparam logic [3:0] S_EFRAME = 4'd4;
    localparam logic [3:0] S_DF     = 4'd5;
    localparam logic [3:0] S_DB     = 4'd6;
    localparam logic [3:0] S_KEY    = 4'd7;
    localparam logic [3:0] S_UF     = 4'd8;
    localparam logic [3:0] S_UB     = 4'd9;
    localparam logic [3:0] S_CHK    = 4'd10;
    localparam logic [3:0] S_CLR    = 4'd11;
    localparam logic [3:0] S_DMOVE  = 4'd12;

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rdata;
    logic [7:0]    r_tmp;
    logic [3:0]    r_state;
    logic [1:0]    r_ph;
    logic          r_sub;
    logic          r_bad;
    logic          r_is_enc;
    logic [NW-1:0] r_i;
    logic [NW-1:0] r_end;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_len;
    logic [31:0]   r_sf;
    logic [31:0]   r_sb;
    logic [63:0]   r_key;
    t_out_word     r_res;
    t_out_word     r_out;
    logic          r_ov;

    logic          w_acc;
    logic          w_idx_ok;
    logic [9:0]    w_enc_n;
    logic          w_enc_ok;
    logic          w_dec_ok;
    logic [NW-1:0] w_inc1;
    logic [NW-1:0] w_inc2;
    logic [NW-1:0] w_dec1;
    logic [NW-1:0] w_dec3;
    logic [NW-1:0] w_dst;
    logic [NW-1:0] w_src;
    logic          w_two;
    logic          w_desc;
    logic          w_last;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_wdata;
    logic          w_miss;

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_acc    = i_in_valid && !o_in_stall;
    assign w_idx_ok = (int'(i_in.byte_index) < BUFFER_BYTES);
    assign w_enc_n  = {1'b0, i_in.packet_length} + 10'd24;
    assign w_enc_ok = (int'(w_enc_n) <= BUFFER_BYTES);
    assign w_dec_ok = (i_in.packet_length >= 9'd24) && (int'(i_in.packet_length) <= BUFFER_BYTES);

    assign w_inc1 = (r_i + NW'(1) == r_n) ? '0 : r_i + NW'(1);
    assign w_inc2 = (r_i + NW'(2) >= r_n) ? r_i + NW'(2) - r_n : r_i + NW'(2);
    assign w_dec1 = (r_i == '0) ? r_n - NW'(1) : r_i - NW'(1);
    assign w_dec3 = (r_i < NW'(3)) ? r_i + r_n - NW'(3) : r_i - NW'(3);

    assign w_two  = (r_state == S_DF) || (r_state == S_DB) || (r_state == S_UF)
                 || (r_state == S_UB);
    assign w_desc = (r_state == S_EMOVE) || (r_state == S_DB) || (r_state == S_UB);
    assign w_last = w_desc ? (r_i == '0) : (r_i == r_end);
    assign w_miss = (r_rdata != check_byte(r_i[3:0]));

    always_comb begin
        w_dst = r_i;
        w_src = r_i;
        unique case (r_state)
            S_EMOVE:  w_dst = r_i + NW'(HEAD_BYTES);
            S_EFRAME: w_dst = (r_i < NW'(HEAD_BYTES)) ? r_i : r_i + r_len;
            S_DF: begin
                w_dst = r_sub ? w_inc2 : r_i;
                w_src = r_sub ? r_i : w_inc1;
            end
            S_DB: begin
                w_dst = r_sub ? w_dec3 : r_i;
                w_src = r_sub ? r_i : w_dec1;
            end
            S_UF: begin
                w_dst = r_sub ? r_i : w_dec3;
                w_src = r_sub ? w_dec1 : r_i;
            end
            S_UB: begin
                w_dst = r_sub ? r_i : w_inc2;
                w_src = r_sub ? w_inc1 : r_i;
            end
            S_CHK:    w_src = (r_i < NW'(8)) ? r_i + NW'(4) : r_n - NW'(20) + r_i;
            S_DMOVE:  w_src = r_i + NW'(HEAD_BYTES);
            default: begin
                w_dst = r_i;
                w_src = r_i;
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(w_dst);
        w_wdata = r_tmp ^ r_rdata;
        w_raddr = (r_ph == 2'd0) ? AW'(w_dst) : AW'(w_src);
        unique case (r_state)
            S_IDLE: begin
                w_raddr = AW'(i_in.byte_index);
                w_waddr = AW'(i_in.byte_index);
                w_wdata = i_in.data_byte;
                w_we    = w_acc && (i_in.operation == OP_WRITE) && w_idx_ok;
            end
            S_EMOVE, S_DMOVE: begin
                w_wdata = r_rdata;
                w_we    = (r_ph == 2'd2);
            end
            S_EFRAME: begin
                w_wdata = frame_byte(r_i[4:0], r_sf, r_sb);
                w_we    = (r_ph == 2'd2);
            end
            S_DF, S_DB, S_UF, S_UB: begin
                w_we = (r_ph == 2'd2);
            end
            S_KEY: begin
                w_wdata = r_tmp ^ r_key[8*r_i[2:0] +: 8];
                w_we    = (r_ph == 2'd2);
            end
            S_CLR: begin
                w_wdata = 8'd0;
                w_we    = (r_ph == 2'd2);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_key   <= '0;
            r_ph    <= 2'd0;
            r_sub   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_key <= i_cfg_data;
            end
            if (r_ov && !i_out_stall && (r_state != S_FIN)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_ph  <= 2'd0;
                    r_sub <= 1'b0;
                    if (w_acc) begin
                        r_res.read_byte     <= '0;
                        r_res.result_length <= '0;
                        r_sf  <= i_in.salt_front;
                        r_sb  <= i_in.salt_back;
                        r_bad <= 1'b0;
                        unique case (i_in.operation)
                            OP_WRITE: begin
                                r_res.status <= w_idx_ok ? ST_OK : ST_RANGE;
                                r_state      <= S_FIN;
                            end
                            OP_READ: begin
                                if (w_idx_ok) begin
                                    r_res.status <= ST_OK;
                                    r_state      <= S_RD;
                                end else begin
                                    r_res.status <= ST_RANGE;
                                    r_state      <= S_FIN;
                                end
                            end
                            OP_ENCODE: begin
                                r_is_enc     <= 1'b1;
                                r_n          <= NW'(w_enc_n);
                                r_len        <= NW'(i_in.packet_length);
                                r_res.status <= w_enc_ok ? ST_OK : ST_RANGE;
                                if (!w_enc_ok) begin
                                    r_state <= S_FIN;
                                end else if (i_in.packet_length == 9'd0) begin
                                    r_i     <= '0;
                                    r_end   <= NW'(FRAME_EXTRA - 1);
                                    r_state <= S_EFRAME;
                                end else begin
                                    r_i     <= NW'(i_in.packet_length - 9'd1);
                                    r_state <= S_EMOVE;
                                end
                            end
                            OP_DECODE: begin
                                r_is_enc     <= 1'b0;
                                r_n          <= NW'(i_in.packet_length);
                                r_i          <= '0;
                                r_end        <= NW'(i_in.packet_length - 9'd1);
                                r_res.status <= w_dec_ok ? ST_OK : ST_RANGE;
                                if (w_dec_ok) begin
                                    r_state <= S_KEY;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                                r_res.status <= ST_OK;
                                r_state      <= S_FIN;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_res.read_byte <= r_rdata;
                    r_state         <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ov || !i_out_stall) begin
                        r_out   <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    if (r_ph == 2'd1) begin
                        r_tmp <= r_rdata;
                    end
                    if (r_ph != 2'd2) begin
                        r_ph <= r_ph + 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if ((r_state == S_CHK) && w_miss) begin
                            r_bad <= 1'b1;
                        end
                        if (w_two && !r_sub) begin
                            r_sub <= 1'b1;
                        end else begin
                            r_sub <= 1'b0;
                            if (!w_last) begin
                                r_i <= w_desc ? r_i - NW'(1) : r_i + NW'(1);
                            end else begin
                                priority case (r_state)
                                    S_EMOVE: begin
                                        r_i     <= '0;
                                        r_end   <= NW'(FRAME_EXTRA - 1);
                                        r_state <= S_EFRAME;
                                    end
                                    S_EFRAME: begin
                                        r_i     <= '0;
                                        r_end   <= r_n - NW'(1);
                                        r_state <= S_DF;
                                    end
                                    S_DF: begin
                                        r_i     <= r_n - NW'(1);
                                        r_state <= S_DB;
                                    end
                                    S_DB: begin
                                        r_i     <= '0;
                                        r_end   <= r_n - NW'(1);
                                        r_state <= S_KEY;
                                    end
                                    S_KEY: begin
                                        if (r_is_enc) begin
                                            r_res.result_length <= 9'(r_n);
                                            r_state             <= S_FIN;
                                        end else begin
                                            r_i     <= '0;
                                            r_end   <= r_n - NW'(1);
                                            r_state <= S_UF;
                                        end
                                    end
                                    S_UF: begin
                                        r_i     <= r_n - NW'(1);
                                        r_state <= S_UB;
                                    end
                                    S_UB: begin
                                        r_i     <= '0;
                                        r_end   <= NW'(15);
                                        r_state <= S_CHK;
                                    end
                                    S_CHK: begin
                                        r_i <= '0;
                                        if (r_bad || w_miss) begin
                                            r_end   <= r_n - NW'(1);
                                            r_state <= S_CLR;
                                        end else begin
                                            r_end   <= r_n - NW'(13);
                                            r_state <= S_DMOVE;
                                        end
                                    end
                                    S_CLR: begin
                                        r_res.status <= ST_MISMATCH;
                                        r_state      <= S_FIN;
                                    end
                                    default: begin
                                        r_res.result_length <= 9'(r_n - NW'(FRAME_EXTRA));
                                        r_state             <= S_FIN;
                                    end
                                endcase
                            end
                        end
                    end
                end
            endcase
        end
    end

endmodule
